>>> rtl/thc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thc_pkg
// Shared types, microcode table and saturation helpers for the hit chi-square
// unit.
// ---------------------------------------------------------------------------
package thc_pkg;

    // default number of fraction bits of every fixed point value
    localparam int unsigned FRAC_BITS_DEF = 16;

    // step counts of the shared iterative unit
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS  = 6'd33;

    // microcode address ranges
    localparam logic [4:0] UPC_SQR_FIRST = 5'd0;
    localparam logic [4:0] UPC_SQR_LAST  = 5'd2;
    localparam logic [4:0] UPC_MAC_FIRST = 5'd3;
    localparam logic [4:0] UPC_MAC_LAST  = 5'd22;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQR,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_RCHK,
        S_DIVA_GO,
        S_DIVA_WAIT,
        S_DIVB_GO,
        S_DIVB_WAIT,
        S_MAC,
        S_DCHK,
        S_DIVC_GO,
        S_DIVC_WAIT,
        S_OUT
    } t_state;

    // multiplier operand pairs
    typedef enum logic [4:0] {
        MUL_NONE,
        MUL_HXHX,
        MUL_HYHY,
        MUL_ADX,
        MUL_BDY,
        MUL_AA,
        MUL_AB,
        MUL_BB,
        MUL_T1E0,
        MUL_T2E1,
        MUL_T3E2,
        MUL_AE3,
        MUL_BE4,
        MUL_U0U0,
        MUL_U0DZ,
        MUL_DZDZ,
        MUL_L00E5,
        MUL_L01L01,
        MUL_E5T1,
        MUL_L01T2,
        MUL_L00T3
    } t_mul_sel;

    // writeback of the product issued in the cycle before
    typedef enum logic [3:0] {
        WB_NONE,
        WB_S_LOAD,
        WB_S_ADD,
        WB_T1,
        WB_T2,
        WB_T3,
        WB_ACC_LD,
        WB_ACC_ADD,
        WB_ACC_ADD2,
        WB_ACC_SUB,
        WB_ACC_SUB2
    } t_wb_sel;

    // store of the saturated accumulator
    typedef enum logic [2:0] {
        ST_NONE,
        ST_U0,
        ST_L00,
        ST_L01,
        ST_DET,
        ST_NUM
    } t_st_sel;

    // job of the shared iterative unit
    typedef enum logic [1:0] {
        IT_ROOT,
        IT_DIVA,
        IT_DIVB,
        IT_DIVC
    } t_iter_sel;

    typedef struct packed {
        t_mul_sel mul;
        t_wb_sel  wb;
        t_st_sel  st;
    } t_ucmd;

    typedef struct packed {
        logic      prep;
        t_ucmd     uop;
        logic      iter_go;
        t_iter_sel iter_sel;
        logic      out_load;
        logic      out_invalid;
    } t_cmd;

    typedef struct packed {
        logic track_valid;
        logic root_zero;
        logic det_zero;
        logic iter_done;
        logic out_free;
    } t_status;

    // microcode: sum of squares, then the local frame multiply-accumulate
    function automatic t_ucmd ucode(input logic [4:0] idx);
        t_ucmd u;
        u = '{MUL_NONE, WB_NONE, ST_NONE};
        case (idx)
            5'd0:  u = '{MUL_HXHX,   WB_NONE,     ST_NONE};
            5'd1:  u = '{MUL_HYHY,   WB_S_LOAD,   ST_NONE};
            5'd2:  u = '{MUL_NONE,   WB_S_ADD,    ST_NONE};
            5'd3:  u = '{MUL_ADX,    WB_NONE,     ST_NONE};
            5'd4:  u = '{MUL_BDY,    WB_ACC_LD,   ST_NONE};
            5'd5:  u = '{MUL_AA,     WB_ACC_ADD,  ST_NONE};
            5'd6:  u = '{MUL_AB,     WB_T1,       ST_U0};
            5'd7:  u = '{MUL_BB,     WB_T2,       ST_NONE};
            5'd8:  u = '{MUL_T1E0,   WB_T3,       ST_NONE};
            5'd9:  u = '{MUL_T2E1,   WB_ACC_LD,   ST_NONE};
            5'd10: u = '{MUL_T3E2,   WB_ACC_ADD2, ST_NONE};
            5'd11: u = '{MUL_AE3,    WB_ACC_ADD,  ST_NONE};
            5'd12: u = '{MUL_BE4,    WB_ACC_LD,   ST_L00};
            5'd13: u = '{MUL_U0U0,   WB_ACC_ADD,  ST_NONE};
            5'd14: u = '{MUL_U0DZ,   WB_T1,       ST_L01};
            5'd15: u = '{MUL_DZDZ,   WB_T2,       ST_NONE};
            5'd16: u = '{MUL_L00E5,  WB_T3,       ST_NONE};
            5'd17: u = '{MUL_L01L01, WB_ACC_LD,   ST_NONE};
            5'd18: u = '{MUL_E5T1,   WB_ACC_SUB,  ST_NONE};
            5'd19: u = '{MUL_L01T2,  WB_ACC_LD,   ST_DET};
            5'd20: u = '{MUL_L00T3,  WB_ACC_SUB2, ST_NONE};
            5'd21: u = '{MUL_NONE,   WB_ACC_ADD,  ST_NONE};
            5'd22: u = '{MUL_NONE,   WB_NONE,     ST_NUM};
            default: u = '{MUL_NONE, WB_NONE, ST_NONE};
        endcase
        return u;
    endfunction

    // clamp a 35-bit signed value to 32 bits
    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // give a magnitude its sign and clamp to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            r = (m > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -m[31:0];
        end else begin
            r = (m > 64'h0000_0000_7fff_ffff) ? 32'sh7fff_ffff : m[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/thc_iter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thc_iter
// Shared radix-2 unit: integer square root (two bits a step) or restoring
// division (one bit a step) with one compare-subtract per cycle.
// ---------------------------------------------------------------------------
module thc_iter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_sqrt,
    input  logic [34:0] i_rem,
    input  logic [63:0] i_sh,
    input  logic [32:0] i_div,
    input  logic [5:0]  i_steps,
    output logic        o_done,
    output logic [32:0] o_q
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt,  n_cnt;
    logic        r_sqrt;
    logic [34:0] r_rem,  n_rem;
    logic [63:0] r_sh,   n_sh;
    logic [32:0] r_div;
    logic [32:0] r_q,    n_q;
    logic [34:0] w_cand;
    logic [34:0] w_trial;
    logic [35:0] w_diff;

    // one step of root or quotient
    always_comb begin
        if (r_sqrt) begin
            w_cand  = {r_rem[32:0], r_sh[63:62]};
            w_trial = {1'b0, r_q[31:0], 2'b01};
        end else begin
            w_cand  = {r_rem[33:0], r_sh[63]};
            w_trial = {2'b00, r_div};
        end
        w_diff = {1'b0, w_cand} - {1'b0, w_trial};
    end

    // control and next state
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_q    = r_q;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_rem  = i_rem;
            n_sh   = i_sh;
            n_q    = '0;
        end else if (r_busy) begin
            if (w_diff[35]) begin
                n_rem = w_cand;
                n_q   = {r_q[31:0], 1'b0};
            end else begin
                n_rem = w_diff[34:0];
                n_q   = {r_q[31:0], 1'b1};
            end
            n_sh  = r_sqrt ? {r_sh[61:0], 2'b00} : {r_sh[62:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_q   <= n_q;
        if (i_go) begin
            r_sqrt <= i_sqrt;
            r_div  <= i_div;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> rtl/thc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thc_datapath
// Track store, input capture, one 32x32 multiplier with saturating
// accumulator, and the shared root/divide unit, driven by controller commands.
// ---------------------------------------------------------------------------
module thc_datapath #(
    parameter int unsigned FRACTION_BITS = thc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_cov_xx,
    input  logic signed [31:0] i_cov_xy,
    input  logic signed [31:0] i_cov_yy,
    input  logic signed [31:0] i_cov_xz,
    input  logic signed [31:0] i_cov_yz,
    input  logic signed [31:0] i_cov_zz,
    input  thc_pkg::t_cmd      i_ctl,
    output thc_pkg::t_status   o_st,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_chi_square,
    output logic               o_invalid
);

    localparam int unsigned NW = 33 + FRACTION_BITS;

    // captured hit and stored track
    logic signed [31:0] r_h [3];
    logic signed [31:0] r_hc [6];
    logic signed [31:0] r_tp [3];
    logic signed [31:0] r_tc [6];
    logic               r_tvalid;

    // working registers
    logic signed [31:0] r_dx, r_dy, r_dz;
    logic signed [31:0] r_e [6];
    logic [63:0]        r_s;
    logic [31:0]        r_root;
    logic signed [31:0] r_a, r_b, r_t1, r_t2, r_t3;
    logic signed [31:0] r_u0, r_l00, r_l01, r_det, r_num, r_chi;
    logic signed [34:0] r_acc;
    logic signed [63:0] r_p;
    thc_pkg::t_iter_sel r_isel;
    logic               r_dneg;
    logic               r_dovf;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_chi;
    logic               r_out_inv;

    logic signed [31:0] w_opa, w_opb;
    logic               w_pneg;
    logic [63:0]        w_pmag;
    logic signed [31:0] w_mq;
    logic signed [34:0] w_mq_ext;
    logic signed [31:0] w_acc_sat;
    logic signed [33:0] w_n;
    logic [32:0]        w_d;
    logic               w_dneg;
    logic [33:0]        w_nmag;
    logic [NW-1:0]      w_nsh;
    logic               w_ovf;
    logic               w_sqrt;
    logic [34:0]        w_rem0;
    logic [63:0]        w_sh0;
    logic [5:0]         w_steps;
    logic               w_done;
    logic [32:0]        w_q;
    logic signed [31:0] w_qsat;

    // multiplier operand select
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_ctl.uop.mul)
            thc_pkg::MUL_HXHX:   begin w_opa = r_h[0]; w_opb = r_h[0]; end
            thc_pkg::MUL_HYHY:   begin w_opa = r_h[1]; w_opb = r_h[1]; end
            thc_pkg::MUL_ADX:    begin w_opa = r_a;    w_opb = r_dx;   end
            thc_pkg::MUL_BDY:    begin w_opa = r_b;    w_opb = r_dy;   end
            thc_pkg::MUL_AA:     begin w_opa = r_a;    w_opb = r_a;    end
            thc_pkg::MUL_AB:     begin w_opa = r_a;    w_opb = r_b;    end
            thc_pkg::MUL_BB:     begin w_opa = r_b;    w_opb = r_b;    end
            thc_pkg::MUL_T1E0:   begin w_opa = r_t1;   w_opb = r_e[0]; end
            thc_pkg::MUL_T2E1:   begin w_opa = r_t2;   w_opb = r_e[1]; end
            thc_pkg::MUL_T3E2:   begin w_opa = r_t3;   w_opb = r_e[2]; end
            thc_pkg::MUL_AE3:    begin w_opa = r_a;    w_opb = r_e[3]; end
            thc_pkg::MUL_BE4:    begin w_opa = r_b;    w_opb = r_e[4]; end
            thc_pkg::MUL_U0U0:   begin w_opa = r_u0;   w_opb = r_u0;   end
            thc_pkg::MUL_U0DZ:   begin w_opa = r_u0;   w_opb = r_dz;   end
            thc_pkg::MUL_DZDZ:   begin w_opa = r_dz;   w_opb = r_dz;   end
            thc_pkg::MUL_L00E5:  begin w_opa = r_l00;  w_opb = r_e[5]; end
            thc_pkg::MUL_L01L01: begin w_opa = r_l01;  w_opb = r_l01;  end
            thc_pkg::MUL_E5T1:   begin w_opa = r_e[5]; w_opb = r_t1;   end
            thc_pkg::MUL_L01T2:  begin w_opa = r_l01;  w_opb = r_t2;   end
            thc_pkg::MUL_L00T3:  begin w_opa = r_l00;  w_opb = r_t3;   end
            default:             begin w_opa = '0;     w_opb = '0;     end
        endcase
    end

    // scaled and saturated product of the previous cycle
    always_comb begin
        w_pneg    = r_p[63];
        w_pmag    = w_pneg ? 64'(-r_p) : 64'(r_p);
        w_mq      = thc_pkg::sat_mag(w_pmag >> FRACTION_BITS, w_pneg);
        w_mq_ext  = 35'(w_mq);
        w_acc_sat = thc_pkg::sat35(r_acc);
    end

    // divider and root operands
    always_comb begin
        w_n    = '0;
        w_d    = {r_root, 1'b0};
        w_dneg = 1'b0;
        case (i_ctl.iter_sel)
            thc_pkg::IT_DIVA: w_n = -(34'(r_h[1]) + 34'(r_tp[1]));
            thc_pkg::IT_DIVB: w_n = 34'(r_h[0]) + 34'(r_tp[0]);
            thc_pkg::IT_DIVC: begin
                w_n    = 34'(r_num);
                w_dneg = r_det[31];
                w_d    = r_det[31] ? 33'(-34'(r_det)) : 33'(r_det);
            end
            default: w_n = '0;
        endcase
        w_nmag = w_n[33] ? -w_n : w_n;
        w_nsh  = {w_nmag[32:0], {FRACTION_BITS{1'b0}}};
        w_ovf  = 33'(w_nsh[NW-1:33]) >= w_d;
        w_sqrt = (i_ctl.iter_sel == thc_pkg::IT_ROOT);
        if (w_sqrt) begin
            w_rem0  = '0;
            w_sh0   = r_s;
            w_steps = thc_pkg::SQRT_STEPS;
        end else begin
            w_rem0  = 35'(w_nsh[NW-1:33]);
            w_sh0   = {w_nsh[32:0], 31'b0};
            w_steps = thc_pkg::DIV_STEPS;
        end
    end

    thc_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctl.iter_go),
        .i_sqrt  (w_sqrt),
        .i_rem   (w_rem0),
        .i_sh    (w_sh0),
        .i_div   (w_d),
        .i_steps (w_steps),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    // signed, saturated quotient
    assign w_qsat = thc_pkg::sat_mag(r_dovf ? 64'h0000_0002_0000_0000 : 64'(w_q), r_dneg);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fire && !i_cmd) begin
                r_tvalid <= 1'b1;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // transaction capture and track load
        if (i_fire) begin
            r_h[0]  <= i_pos_x;
            r_h[1]  <= i_pos_y;
            r_h[2]  <= i_pos_z;
            r_hc[0] <= i_cov_xx;
            r_hc[1] <= i_cov_xy;
            r_hc[2] <= i_cov_yy;
            r_hc[3] <= i_cov_xz;
            r_hc[4] <= i_cov_yz;
            r_hc[5] <= i_cov_zz;
            if (!i_cmd) begin
                r_tp[0] <= i_pos_x;
                r_tp[1] <= i_pos_y;
                r_tp[2] <= i_pos_z;
                r_tc[0] <= i_cov_xx;
                r_tc[1] <= i_cov_xy;
                r_tc[2] <= i_cov_yy;
                r_tc[3] <= i_cov_xz;
                r_tc[4] <= i_cov_yz;
                r_tc[5] <= i_cov_zz;
            end
        end

        // residual and summed covariance
        if (i_ctl.prep) begin
            r_dx <= thc_pkg::sat35(35'(r_h[0]) - 35'(r_tp[0]));
            r_dy <= thc_pkg::sat35(35'(r_h[1]) - 35'(r_tp[1]));
            r_dz <= thc_pkg::sat35(35'(r_h[2]) - 35'(r_tp[2]));
            for (int k = 0; k < 6; k++) begin
                r_e[k] <= thc_pkg::sat35(35'(r_hc[k]) + 35'(r_tc[k]));
            end
        end

        // multiplier stage
        r_p <= 64'(w_opa) * 64'(w_opb);

        // product writeback
        case (i_ctl.uop.wb)
            thc_pkg::WB_S_LOAD:   r_s   <= 64'(r_p);
            thc_pkg::WB_S_ADD:    r_s   <= r_s + 64'(r_p);
            thc_pkg::WB_T1:       r_t1  <= w_mq;
            thc_pkg::WB_T2:       r_t2  <= w_mq;
            thc_pkg::WB_T3:       r_t3  <= w_mq;
            thc_pkg::WB_ACC_LD:   r_acc <= w_mq_ext;
            thc_pkg::WB_ACC_ADD:  r_acc <= r_acc + w_mq_ext;
            thc_pkg::WB_ACC_ADD2: r_acc <= r_acc + (w_mq_ext <<< 1);
            thc_pkg::WB_ACC_SUB:  r_acc <= r_acc - w_mq_ext;
            thc_pkg::WB_ACC_SUB2: r_acc <= r_acc - (w_mq_ext <<< 1);
            default: ;
        endcase

        // accumulator store
        case (i_ctl.uop.st)
            thc_pkg::ST_U0:  r_u0  <= w_acc_sat;
            thc_pkg::ST_L00: r_l00 <= w_acc_sat;
            thc_pkg::ST_L01: r_l01 <= w_acc_sat;
            thc_pkg::ST_DET: r_det <= w_acc_sat;
            thc_pkg::ST_NUM: r_num <= w_acc_sat;
            default: ;
        endcase

        // iterative unit launch and result
        if (i_ctl.iter_go) begin
            r_isel <= i_ctl.iter_sel;
            r_dneg <= w_n[33] ^ w_dneg;
            r_dovf <= w_ovf;
        end
        if (w_done) begin
            case (r_isel)
                thc_pkg::IT_ROOT: r_root <= w_q[31:0];
                thc_pkg::IT_DIVA: r_a    <= w_qsat;
                thc_pkg::IT_DIVB: r_b    <= w_qsat;
                thc_pkg::IT_DIVC: r_chi  <= w_qsat;
                default: ;
            endcase
        end

        // result register
        if (i_ctl.out_load) begin
            r_out_chi <= i_ctl.out_invalid ? '0 : r_chi;
            r_out_inv <= i_ctl.out_invalid;
        end
    end

    // status to the controller
    always_comb begin
        o_st.track_valid = r_tvalid;
        o_st.root_zero   = (r_root == '0);
        o_st.det_zero    = (r_det == '0);
        o_st.iter_done   = w_done;
        o_st.out_free    = !r_out_valid || i_ready;
    end

    assign o_valid      = r_out_valid;
    assign o_chi_square = r_out_chi;
    assign o_invalid    = r_out_inv;

endmodule

>>> rtl/thc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thc_ctrl
// Sequencer for one hit: capture, sum of squares, root, two divisions,
// multiply-accumulate microcode, final division and result hand-off.
// ---------------------------------------------------------------------------
module thc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_hit,
    output logic             o_ready,
    input  thc_pkg::t_status i_st,
    output thc_pkg::t_cmd    o_cmd
);

    thc_pkg::t_state r_state, n_state;
    logic [4:0]      r_upc,   n_upc;
    logic            r_inv,   n_inv;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thc_pkg::S_IDLE;
            r_upc   <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_inv   <= n_inv;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        n_inv   = r_inv;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            thc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_hit) begin
                    n_state = thc_pkg::S_PREP;
                end
            end
            thc_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                if (!i_st.track_valid) begin
                    n_inv   = 1'b1;
                    n_state = thc_pkg::S_OUT;
                end else begin
                    n_inv   = 1'b0;
                    n_upc   = thc_pkg::UPC_SQR_FIRST;
                    n_state = thc_pkg::S_SQR;
                end
            end
            thc_pkg::S_SQR: begin
                o_cmd.uop = thc_pkg::ucode(r_upc);
                n_upc     = r_upc + 5'd1;
                if (r_upc == thc_pkg::UPC_SQR_LAST) begin
                    n_state = thc_pkg::S_ROOT_GO;
                end
            end
            thc_pkg::S_ROOT_GO: begin
                o_cmd.iter_go  = 1'b1;
                o_cmd.iter_sel = thc_pkg::IT_ROOT;
                n_state        = thc_pkg::S_ROOT_WAIT;
            end
            thc_pkg::S_ROOT_WAIT: begin
                if (i_st.iter_done) begin
                    n_state = thc_pkg::S_RCHK;
                end
            end
            thc_pkg::S_RCHK: begin
                if (i_st.root_zero) begin
                    n_inv   = 1'b1;
                    n_state = thc_pkg::S_OUT;
                end else begin
                    n_state = thc_pkg::S_DIVA_GO;
                end
            end
            thc_pkg::S_DIVA_GO: begin
                o_cmd.iter_go  = 1'b1;
                o_cmd.iter_sel = thc_pkg::IT_DIVA;
                n_state        = thc_pkg::S_DIVA_WAIT;
            end
            thc_pkg::S_DIVA_WAIT: begin
                if (i_st.iter_done) begin
                    n_state = thc_pkg::S_DIVB_GO;
                end
            end
            thc_pkg::S_DIVB_GO: begin
                o_cmd.iter_go  = 1'b1;
                o_cmd.iter_sel = thc_pkg::IT_DIVB;
                n_state        = thc_pkg::S_DIVB_WAIT;
            end
            thc_pkg::S_DIVB_WAIT: begin
                if (i_st.iter_done) begin
                    n_upc   = thc_pkg::UPC_MAC_FIRST;
                    n_state = thc_pkg::S_MAC;
                end
            end
            thc_pkg::S_MAC: begin
                o_cmd.uop = thc_pkg::ucode(r_upc);
                n_upc     = r_upc + 5'd1;
                if (r_upc == thc_pkg::UPC_MAC_LAST) begin
                    n_state = thc_pkg::S_DCHK;
                end
            end
            thc_pkg::S_DCHK: begin
                if (i_st.det_zero) begin
                    n_inv   = 1'b1;
                    n_state = thc_pkg::S_OUT;
                end else begin
                    n_state = thc_pkg::S_DIVC_GO;
                end
            end
            thc_pkg::S_DIVC_GO: begin
                o_cmd.iter_go  = 1'b1;
                o_cmd.iter_sel = thc_pkg::IT_DIVC;
                n_state        = thc_pkg::S_DIVC_WAIT;
            end
            thc_pkg::S_DIVC_WAIT: begin
                if (i_st.iter_done) begin
                    n_state = thc_pkg::S_OUT;
                end
            end
            thc_pkg::S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_invalid = r_inv;
                    n_state           = thc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = thc_pkg::S_IDLE;
            end
        endcase
    end

    // a finished result waits in S_OUT until the output register frees up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == thc_pkg::S_OUT && !i_st.out_free) |=> (r_state == thc_pkg::S_OUT))
        else $error("result dropped while output register busy");

    // the iterative unit only finishes while a wait state expects it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.iter_done |-> (r_state == thc_pkg::S_ROOT_WAIT ||
                            r_state == thc_pkg::S_DIVA_WAIT ||
                            r_state == thc_pkg::S_DIVB_WAIT ||
                            r_state == thc_pkg::S_DIVC_WAIT))
        else $error("iterative unit done outside a wait state");

    // microcode address stays inside the running program
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == thc_pkg::S_MAC) |-> (r_upc >= thc_pkg::UPC_MAC_FIRST &&
                                         r_upc <= thc_pkg::UPC_MAC_LAST))
        else $error("microcode address out of range");

endmodule

>>> rtl/track_hit_chi2_local_frame_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// track_hit_chi2_local_frame_unit
// Chi-square of a hit against a stored track in the local measurement frame.
// ---------------------------------------------------------------------------
// A load transaction (cmd 0) stores the track and the next
// transaction can follow at once. A hit transaction (cmd 1) runs a
// 32-step square root and three 33-step divisions on the single shared
// radix-2 root/divide unit, plus the microcode on the one 32x32
// multiplier. Hits with no track, zero radius or zero determinant
// finish early with invalid set. One hit is in flight at a time; a
// finished result sits in an output register so the next transaction
// is accepted while it waits to be taken.
// ---------------------------------------------------------------------------
module track_hit_chi2_local_frame_unit #(
    parameter int unsigned FRACTION_BITS = thc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_cov_xx,
    input  logic signed [31:0] i_cov_xy,
    input  logic signed [31:0] i_cov_yy,
    input  logic signed [31:0] i_cov_xz,
    input  logic signed [31:0] i_cov_yz,
    input  logic signed [31:0] i_cov_zz,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_chi_square,
    output logic               o_invalid
);

    thc_pkg::t_cmd    w_cmd;
    thc_pkg::t_status w_st;
    logic             w_fire;

    assign w_fire = i_valid && o_ready;

    thc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_hit   (i_cmd),
        .o_ready (o_ready),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    thc_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_cov_xx     (i_cov_xx),
        .i_cov_xy     (i_cov_xy),
        .i_cov_yy     (i_cov_yy),
        .i_cov_xz     (i_cov_xz),
        .i_cov_yz     (i_cov_yz),
        .i_cov_zz     (i_cov_zz),
        .i_ctl        (w_cmd),
        .o_st         (w_st),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chi_square (o_chi_square),
        .o_invalid    (o_invalid)
    );

endmodule

>>> test/track_hit_chi2_local_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// track_hit_chi2_local_frame_checker
// Watches both channels of the hit chi-square unit, predicts the chi-square
// of every hit transaction from its own copy of the track and compares the
// results in order.
// ---------------------------------------------------------------------------
module track_hit_chi2_local_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_cov_xx,
    input  logic signed [31:0] i_cov_xy,
    input  logic signed [31:0] i_cov_yy,
    input  logic signed [31:0] i_cov_xz,
    input  logic signed [31:0] i_cov_yz,
    input  logic signed [31:0] i_cov_zz,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic signed [31:0] i_chi_square,
    input  logic               i_invalid,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FB = thc_pkg::FRAC_BITS_DEF;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] chi;
        logic               inv;
    } t_chi_result;

    // stored track
    longint    trk_pos[3];
    longint    trk_cov[6];
    bit        trk_loaded;

    t_chi_result chi_expect_q[$];
    int          result_idx;

    function automatic longint clamp32(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // signed magnitude clamped to 32 bits
    function automatic longint signed_clamp(input longint unsigned m, input bit neg);
        if (neg) return (m >= 64'd2147483648) ? SMIN : -longint'(m);
        return (m > 64'd2147483647) ? SMAX : longint'(m);
    endfunction

    function automatic longint fx_mul(input longint x, input longint y);
        longint p;
        p = x * y;
        return signed_clamp(magnitude(p) >> FB, p < 0);
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        longint unsigned m;
        if (d == 0) return 0;
        m = (magnitude(n) << FB) / magnitude(d);
        return signed_clamp(m, (n < 0) != (d < 0));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // chi-square of one hit against the stored track
    function automatic t_chi_result predict_chi2(input longint h[3], input longint hc[6]);
        t_chi_result      r;
        longint           d[3];
        longint           e[6];
        longint unsigned  ssq;
        longint unsigned  rad;
        longint           a, b, u0, u1, l00, l01, l11, det, num;
        r.chi = '0;
        r.inv = 1'b1;
        if (!trk_loaded) return r;
        ssq = magnitude(h[0]) * magnitude(h[0]) + magnitude(h[1]) * magnitude(h[1]);
        rad = int_sqrt(ssq);
        if (rad == 0) return r;
        for (int i = 0; i < 3; i++) d[i] = clamp32(h[i] - trk_pos[i]);
        for (int i = 0; i < 6; i++) e[i] = clamp32(hc[i] + trk_cov[i]);
        a   = fx_div(-(h[1] + trk_pos[1]), longint'(2 * rad));
        b   = fx_div(h[0] + trk_pos[0], longint'(2 * rad));
        u0  = clamp32(fx_mul(a, d[0]) + fx_mul(b, d[1]));
        u1  = d[2];
        l00 = clamp32(fx_mul(fx_mul(a, a), e[0]) + 2 * fx_mul(fx_mul(a, b), e[1])
                      + fx_mul(fx_mul(b, b), e[2]));
        l01 = clamp32(fx_mul(a, e[3]) + fx_mul(b, e[4]));
        l11 = e[5];
        det = clamp32(fx_mul(l00, l11) - fx_mul(l01, l01));
        if (det == 0) return r;
        num = clamp32(fx_mul(l11, fx_mul(u0, u0)) - 2 * fx_mul(l01, fx_mul(u0, u1))
                      + fx_mul(l00, fx_mul(u1, u1)));
        r.chi = 32'(fx_div(num, det));
        r.inv = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t result %0d: %s", $realtime, result_idx, what);
        o_fail_count++;
    endtask

    assign o_pending = chi_expect_q.size();

    // input side: update the track or queue the expected chi-square
    always @(posedge i_clk) begin
        longint h[3];
        longint hc[6];
        if (!i_rst_n) begin
            trk_loaded = 1'b0;
            for (int i = 0; i < 3; i++) trk_pos[i] = 0;
            for (int i = 0; i < 6; i++) trk_cov[i] = 0;
        end else if (i_valid && i_ready_in) begin
            h  = '{i_pos_x, i_pos_y, i_pos_z};
            hc = '{i_cov_xx, i_cov_xy, i_cov_yy, i_cov_xz, i_cov_yz, i_cov_zz};
            if (i_cmd == 1'b0) begin
                trk_pos    = h;
                trk_cov    = hc;
                trk_loaded = 1'b1;
            end else begin
                chi_expect_q.push_back(predict_chi2(h, hc));
            end
        end
    end

    // output side: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_chi_result ex;
        if (i_rst_n && i_res_valid && i_res_ready) begin
            if (chi_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                ex = chi_expect_q.pop_front();
                if (i_invalid !== ex.inv)
                    report_mismatch($sformatf("invalid %b, expected %b", i_invalid, ex.inv));
                if (i_chi_square !== ex.chi)
                    report_mismatch($sformatf("chi_square %h, expected %h",
                                              i_chi_square, ex.chi));
            end
            result_idx++;
        end
    end

    initial begin
        o_fail_count = 0;
        result_idx   = 0;
        trk_loaded   = 1'b0;
    end

endmodule

>>> test/track_hit_chi2_local_frame_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// track_hit_chi2_local_frame_unit_tb
// Drives track loads and hit transactions into the chi-square unit with
// random idle bursts on both sides and one long output stall; the checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module track_hit_chi2_local_frame_unit_tb;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_HIT  = 1'b1;
    localparam int   N_RANDOM = 1800;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_cmd;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_cov_xx, i_cov_xy, i_cov_yy, i_cov_xz, i_cov_yz, i_cov_zz;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_chi_square;
    logic               o_invalid;

    int fail_count;
    int pending;
    bit rx_quiet;
    bit rx_hold;

    typedef logic signed [31:0] t_fields[9];

    track_hit_chi2_local_frame_unit dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd,
        .i_pos_x, .i_pos_y, .i_pos_z,
        .i_cov_xx, .i_cov_xy, .i_cov_yy, .i_cov_xz, .i_cov_yz, .i_cov_zz,
        .o_valid, .i_ready, .o_chi_square, .o_invalid
    );

    track_hit_chi2_local_frame_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_cmd,
        .i_pos_x, .i_pos_y, .i_pos_z,
        .i_cov_xx, .i_cov_xy, .i_cov_yy, .i_cov_xz, .i_cov_yz, .i_cov_zz,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_chi_square(o_chi_square), .i_invalid(o_invalid),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random value: mostly modest, sometimes full range or an extreme
    function automatic logic signed [31:0] rand_fx(input bit positive);
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:       v = $urandom;
            1:       v = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            2:       v = $signed($urandom_range(511)) - 256;
            default: v = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
        if (positive && $urandom_range(3) != 0) v = (v < 0) ? -v : v;
        return v;
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_item(input logic cmd, input t_fields f);
        i_cmd    <= cmd;
        i_pos_x  <= f[0];
        i_pos_y  <= f[1];
        i_pos_z  <= f[2];
        i_cov_xx <= f[3];
        i_cov_xy <= f[4];
        i_cov_yy <= f[5];
        i_cov_xz <= f[6];
        i_cov_yz <= f[7];
        i_cov_zz <= f[8];
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic sender_gap(input bit allow);
        int n;
        if (allow && $urandom_range(3) == 0) begin
            n = $urandom_range(13, 1);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver: random stall bursts, quiet at the end, one long hold-off
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_ready <= 1'b1;
        end else if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(4) == 0) begin
            n = $urandom_range(13, 1);
            i_ready <= 1'b0;
            repeat (n) @(posedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // long output stall counted in its own process
    initial begin
        rx_hold = 1'b0;
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (2000) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // stimulus
    initial begin
        t_fields f;
        logic    cmd;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_cmd    <= CMD_LOAD;
        i_pos_x  <= '0; i_pos_y  <= '0; i_pos_z  <= '0;
        i_cov_xx <= '0; i_cov_xy <= '0; i_cov_yy <= '0;
        i_cov_xz <= '0; i_cov_yz <= '0; i_cov_zz <= '0;
        rx_quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hit before any track is loaded
        send_item(CMD_HIT, '{32'sh0001_0000, 32'sh0002_0000, 0, 1, 2, 3, 4, 5, 6});
        // well-conditioned track and a matching hit
        send_item(CMD_LOAD, '{32'sh0001_0000, 32'sh0000_8000, 32'sh0003_0000,
                              32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000});
        send_item(CMD_HIT, '{32'sh0001_2000, 32'sh0000_a000, 32'sh0002_0000,
                             32'sh0000_8000, 32'sh0000_1000, 32'sh0000_8000,
                             32'sh0000_0800, 32'sh0000_0400, 32'sh0000_8000});
        // zero radius
        send_item(CMD_HIT, '{0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0001_0000,
                             0, 0, 32'sh0001_0000});
        // hit at extreme positions, saturating sums and products
        send_item(CMD_HIT, '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                             32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                             32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
        send_item(CMD_HIT, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        // reload with zero covariance; zero covariance hit gives zero determinant
        send_item(CMD_LOAD, '{32'sh0002_0000, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0});
        send_item(CMD_HIT, '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                             0, 0, 0, 0, 0, 0});
        send_item(CMD_HIT, '{1, 0, 0, 0, 0, 0, 0, 0, 32'sh0001_0000});
        // extreme track
        send_item(CMD_LOAD, '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_item(CMD_HIT, '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                             0, 0, 0, 0, 0, 0});
        send_item(CMD_HIT, '{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_item(CMD_LOAD, '{-1, 0, 32'sh0000_0001, 32'sh0000_0100, 32'sh0000_0010,
                              32'sh0000_0100, 1, 1, 32'sh0000_0100});
        send_item(CMD_HIT, '{1, 32'sh0000_0003, 32'sh7fff_ffff, 1, 1, 1, 1, 1, 1});

        // random part: mostly hits against reloaded tracks
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k > N_RANDOM - 150) rx_quiet = 1'b1;
            sender_gap(!rx_quiet);
            cmd = ($urandom_range(9) < 3) ? CMD_LOAD : CMD_HIT;
            for (int j = 0; j < 9; j++) f[j] = rand_fx(j >= 3);
            if ($urandom_range(19) == 0) begin
                f[0] = 0;
                f[1] = 0;
            end
            if ($urandom_range(19) == 0) for (int j = 3; j < 9; j++) f[j] = 0;
            send_item(cmd, f);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> track_hit_chi2_local_frame_unit.f
rtl/thc_pkg.sv
rtl/thc_iter.sv
rtl/thc_datapath.sv
rtl/thc_ctrl.sv
rtl/track_hit_chi2_local_frame_unit.sv
test/track_hit_chi2_local_frame_checker.sv
test/track_hit_chi2_local_frame_unit_tb.sv
